>>> rtl/core/sttbl_pkg.sv
// Shared types and constants for the sorted timer table.
`timescale 1ns / 1ps
package sttbl_pkg;

    localparam int SLOTS       = 16;
    localparam int TIME_BITS   = 28;
    localparam int EXP_BITS    = TIME_BITS + 1;
    localparam int OWNER_W     = 32;
    localparam int MSG_W       = 16;
    localparam int REP_W       = 16;
    localparam int KIND_W      = 3;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_FIRED     = 3'd0,
        KIND_SET       = 3'd1,
        KIND_CANCELLED = 3'd2,
        KIND_IGNORED   = 3'd3,
        KIND_FULL      = 3'd4
    } t_kind;

    typedef struct packed {
        logic [OWNER_W-1:0]   own;
        logic [MSG_W-1:0]     msg;
        logic [TIME_BITS-1:0] per;
        logic [REP_W-1:0]     reps;
        logic                 ever;
        logic [EXP_BITS-1:0]  exp;
    } t_entry;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_TSTEP,
        CMD_TEND,
        CMD_POP,
        CMD_ISTEP,
        CMD_USTEP,
        CMD_RSTEP,
        CMD_UDEC,
        CMD_URES
    } t_cmd;

    typedef struct packed {
        logic used_zero;
        logic scan_end;
        logic tstep_ok;
        logic hold_v;
        logic stack_empty;
        logic ins_done;
        logic match;
        logic rm_last;
        logic ins_needed;
        logic out_free;
        logic is_tick;
    } t_status;

endpackage

>>> rtl/core/sttbl_ctrl.sv
// Sequencer for scan, compaction, removal and sorted insertion.
`timescale 1ns / 1ps
module sttbl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_action,
    input  sttbl_pkg::t_status i_status,
    output sttbl_pkg::t_cmd    o_cmd,
    output logic               o_busy
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TSCAN,
        ST_POP,
        ST_INS,
        ST_USCAN,
        ST_REMOVE,
        ST_UDEC,
        ST_URES
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = sttbl_pkg::CMD_NOP;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd = sttbl_pkg::CMD_LOAD;
                    if (i_action) begin
                        n_state = ST_USCAN;
                    end else if (!i_status.used_zero) begin
                        n_state = ST_TSCAN;
                    end
                end
            end
            ST_TSCAN: begin
                if (i_status.scan_end) begin
                    if (!i_status.hold_v || i_status.out_free) begin
                        o_cmd   = sttbl_pkg::CMD_TEND;
                        n_state = ST_POP;
                    end
                end else if (i_status.tstep_ok) begin
                    o_cmd = sttbl_pkg::CMD_TSTEP;
                end
            end
            ST_POP: begin
                o_cmd   = sttbl_pkg::CMD_POP;
                n_state = i_status.stack_empty ? ST_IDLE : ST_INS;
            end
            ST_INS: begin
                o_cmd = sttbl_pkg::CMD_ISTEP;
                if (i_status.ins_done) begin
                    n_state = i_status.is_tick ? ST_POP : ST_URES;
                end
            end
            ST_USCAN: begin
                if (i_status.scan_end) begin
                    n_state = ST_UDEC;
                end else begin
                    o_cmd = sttbl_pkg::CMD_USTEP;
                    if (i_status.match) begin
                        n_state = ST_REMOVE;
                    end
                end
            end
            ST_REMOVE: begin
                o_cmd = sttbl_pkg::CMD_RSTEP;
                if (i_status.rm_last) begin
                    n_state = ST_UDEC;
                end
            end
            ST_UDEC: begin
                o_cmd   = sttbl_pkg::CMD_UDEC;
                n_state = i_status.ins_needed ? ST_INS : ST_URES;
            end
            ST_URES: begin
                if (i_status.out_free) begin
                    o_cmd   = sttbl_pkg::CMD_URES;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

>>> rtl/core/sttbl_dp.sv
// Timer table storage, fired-timer stack, counters and result register.
`timescale 1ns / 1ps
module sttbl_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sttbl_pkg::t_cmd                     i_cmd,
    input  logic                                i_action,
    input  logic [sttbl_pkg::TIME_BITS-1:0]     i_now,
    input  logic [sttbl_pkg::OWNER_W-1:0]       i_owner,
    input  logic [sttbl_pkg::MSG_W-1:0]         i_message_id,
    input  logic [sttbl_pkg::TIME_BITS-1:0]     i_interval,
    input  logic [sttbl_pkg::REP_W-1:0]         i_repeat_count,
    input  logic                                i_repeat_forever,
    input  logic                                i_out_stall,
    output sttbl_pkg::t_status                  o_status,
    output logic                                o_valid,
    output logic [sttbl_pkg::KIND_W-1:0]        o_kind,
    output logic [sttbl_pkg::OWNER_W-1:0]       o_owner_out,
    output logic [sttbl_pkg::MSG_W-1:0]         o_message_out,
    output logic [sttbl_pkg::TIME_BITS-1:0]     o_fire_time,
    output logic                                o_last
);

    localparam int TB = sttbl_pkg::TIME_BITS;
    localparam int EB = sttbl_pkg::EXP_BITS;
    localparam int IW = sttbl_pkg::IDX_W;
    localparam int CW = sttbl_pkg::CNT_W;

    sttbl_pkg::t_entry r_tab [sttbl_pkg::SLOTS];
    sttbl_pkg::t_entry r_stk [sttbl_pkg::SLOTS];
    sttbl_pkg::t_entry r_ins;

    logic [CW-1:0]                  r_used;
    logic [CW-1:0]                  r_idx;
    logic [CW-1:0]                  r_wr;
    logic [CW-1:0]                  r_sp;
    logic [sttbl_pkg::NRES_W-1:0]   r_nres;
    logic [TB-1:0]                  r_prev;
    logic                           r_wrap;
    logic                           r_act;
    logic [TB-1:0]                  r_now;
    logic [sttbl_pkg::OWNER_W-1:0]  r_kown;
    logic [sttbl_pkg::MSG_W-1:0]    r_kmsg;
    logic [TB-1:0]                  r_kper;
    logic [sttbl_pkg::REP_W-1:0]    r_krep;
    logic                           r_kev;
    logic                           r_found;
    sttbl_pkg::t_kind               r_kind;
    logic                           r_hold_v;
    logic [sttbl_pkg::OWNER_W-1:0]  r_hold_own;
    logic [sttbl_pkg::MSG_W-1:0]    r_hold_msg;

    logic                           r_ov;
    sttbl_pkg::t_kind               r_o_kind;
    logic [sttbl_pkg::OWNER_W-1:0]  r_o_own;
    logic [sttbl_pkg::MSG_W-1:0]    r_o_msg;
    logic [TB-1:0]                  r_o_time;
    logic                           r_o_last;

    logic [CW-1:0]                  rd_addr;
    sttbl_pkg::t_entry              rd_e;
    logic [EB-1:0]                  exp_w;
    logic [EB-1:0]                  now_x;
    logic [EB:0]                    sum_a;
    logic [EB-1:0]                  exp_a;
    logic [EB-1:0]                  exp_b;
    logic [sttbl_pkg::REP_W-1:0]    rep_dec;
    logic                           expired;
    logic                           emitting;
    logic                           survive;
    logic                           out_free;
    logic                           cancel;
    sttbl_pkg::t_entry              fire_e;
    sttbl_pkg::t_entry              kept_e;
    sttbl_pkg::t_entry              req_e;
    logic [CW:0]                    idx_p1;

    always_comb begin
        unique case (i_cmd)
            sttbl_pkg::CMD_ISTEP: rd_addr = r_idx - CW'(1);
            sttbl_pkg::CMD_RSTEP: rd_addr = r_idx + CW'(1);
            default:              rd_addr = r_idx;
        endcase
    end

    assign rd_e  = r_tab[rd_addr[IW-1:0]];
    assign now_x = {1'b0, r_now};

    // on wrap, expiries past the span drop by the span, others go to zero
    always_comb begin
        if (r_wrap) begin
            exp_w = rd_e.exp[EB-1] ? {1'b0, rd_e.exp[EB-2:0]} : '0;
        end else begin
            exp_w = rd_e.exp;
        end
    end

    assign expired  = (exp_w <= now_x);
    assign emitting = expired && (r_nres < sttbl_pkg::NRES_W'(sttbl_pkg::MAX_RESULTS));
    assign rep_dec  = rd_e.ever ? rd_e.reps : rd_e.reps - sttbl_pkg::REP_W'(1);
    assign survive  = rd_e.ever || (rep_dec != '0);
    assign sum_a    = {1'b0, exp_w} + (EB + 1)'(rd_e.per);
    assign exp_a    = sum_a[EB-1:0];
    assign exp_b    = (exp_a < now_x) ? (now_x + EB'(rd_e.per)) : exp_a;
    assign out_free = !r_ov || !i_out_stall;
    assign cancel   = (r_kper == '0) || ((r_krep == '0) && !r_kev);
    assign idx_p1   = (CW + 1)'(r_idx) + (CW + 1)'(1);

    always_comb begin
        fire_e      = rd_e;
        fire_e.reps = rep_dec;
        fire_e.exp  = exp_b;
        kept_e      = rd_e;
        kept_e.exp  = exp_w;
        req_e.own   = r_kown;
        req_e.msg   = r_kmsg;
        req_e.per   = r_kper;
        req_e.reps  = r_krep;
        req_e.ever  = r_kev;
        req_e.exp   = now_x + EB'(r_kper);
    end

    always_comb begin
        o_status.used_zero   = (r_used == '0);
        o_status.scan_end    = (r_idx == r_used);
        o_status.tstep_ok    = !(emitting && r_hold_v && !out_free);
        o_status.hold_v      = r_hold_v;
        o_status.stack_empty = (r_sp == '0);
        o_status.ins_done    = (r_idx == '0) || (rd_e.exp <= r_ins.exp);
        o_status.match       = (rd_e.own == r_kown) && (rd_e.msg == r_kmsg);
        o_status.rm_last     = (idx_p1 >= (CW + 1)'(r_used));
        o_status.ins_needed  = !cancel && (r_found || (r_used != CW'(sttbl_pkg::SLOTS)));
        o_status.out_free    = out_free;
        o_status.is_tick     = !r_act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_prev   <= '0;
            r_ov     <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (i_cmd)
                sttbl_pkg::CMD_LOAD: begin
                    r_act    <= i_action;
                    r_now    <= i_now;
                    r_kown   <= i_owner;
                    r_kmsg   <= i_message_id;
                    r_kper   <= i_interval;
                    r_krep   <= i_repeat_count;
                    r_kev    <= i_repeat_forever;
                    r_idx    <= '0;
                    r_wr     <= '0;
                    r_sp     <= '0;
                    r_nres   <= '0;
                    r_hold_v <= 1'b0;
                    r_found  <= 1'b0;
                    if (!i_action) begin
                        r_wrap <= (i_now < r_prev);
                        r_prev <= i_now;
                    end
                end
                sttbl_pkg::CMD_TSTEP: begin
                    if (expired) begin
                        if (emitting) begin
                            r_nres     <= r_nres + sttbl_pkg::NRES_W'(1);
                            r_hold_v   <= 1'b1;
                            r_hold_own <= rd_e.own;
                            r_hold_msg <= rd_e.msg;
                            if (r_hold_v) begin
                                r_ov     <= 1'b1;
                                r_o_kind <= sttbl_pkg::KIND_FIRED;
                                r_o_own  <= r_hold_own;
                                r_o_msg  <= r_hold_msg;
                                r_o_time <= r_now;
                                r_o_last <= 1'b0;
                            end
                        end
                        if (survive) begin
                            r_stk[r_sp[IW-1:0]] <= fire_e;
                            r_sp                <= r_sp + CW'(1);
                        end
                    end else begin
                        r_tab[r_wr[IW-1:0]] <= kept_e;
                        r_wr                <= r_wr + CW'(1);
                    end
                    r_idx <= r_idx + CW'(1);
                end
                sttbl_pkg::CMD_TEND: begin
                    r_used <= r_wr;
                    if (r_hold_v) begin
                        r_hold_v <= 1'b0;
                        r_ov     <= 1'b1;
                        r_o_kind <= sttbl_pkg::KIND_FIRED;
                        r_o_own  <= r_hold_own;
                        r_o_msg  <= r_hold_msg;
                        r_o_time <= r_now;
                        r_o_last <= 1'b1;
                    end
                end
                sttbl_pkg::CMD_POP: begin
                    if (r_sp != '0) begin
                        r_ins <= r_stk[r_sp[IW-1:0] - IW'(1)];
                        r_sp  <= r_sp - CW'(1);
                        r_idx <= r_used;
                    end
                end
                sttbl_pkg::CMD_ISTEP: begin
                    if (o_status.ins_done) begin
                        r_tab[r_idx[IW-1:0]] <= r_ins;
                        r_used               <= r_used + CW'(1);
                    end else begin
                        r_tab[r_idx[IW-1:0]] <= rd_e;
                        r_idx                <= r_idx - CW'(1);
                    end
                end
                sttbl_pkg::CMD_USTEP: begin
                    if (o_status.match) begin
                        r_found <= 1'b1;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                sttbl_pkg::CMD_RSTEP: begin
                    if (o_status.rm_last) begin
                        r_used <= r_used - CW'(1);
                    end else begin
                        r_tab[r_idx[IW-1:0]] <= rd_e;
                        r_idx                <= r_idx + CW'(1);
                    end
                end
                sttbl_pkg::CMD_UDEC: begin
                    r_ins <= req_e;
                    r_idx <= r_used;
                    if (cancel) begin
                        r_kind <= r_found ? sttbl_pkg::KIND_CANCELLED : sttbl_pkg::KIND_IGNORED;
                    end else if (!o_status.ins_needed) begin
                        r_kind <= sttbl_pkg::KIND_FULL;
                    end else begin
                        r_kind <= sttbl_pkg::KIND_SET;
                    end
                end
                sttbl_pkg::CMD_URES: begin
                    r_ov     <= 1'b1;
                    r_o_kind <= r_kind;
                    r_o_own  <= r_kown;
                    r_o_msg  <= r_kmsg;
                    r_o_time <= '0;
                    r_o_last <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid       = r_ov;
    assign o_kind        = r_o_kind;
    assign o_owner_out   = r_o_own;
    assign o_message_out = r_o_msg;
    assign o_fire_time   = r_o_time;
    assign o_last        = r_o_last;

endmodule

>>> rtl/core/sorted_timer_table.sv
// Top level of the sorted timer table.
`timescale 1ns / 1ps
// Keeps up to 16 timers sorted by expiry, keyed by owner and message id. A tick request
// (action 0) scans the table once, one slot per cycle unless a stalled output holds the
// scan, emitting a fire result per expired timer and compacting the rest; each surviving
// fired timer is then put back by a backward shift-insert, one slot per cycle. An update
// (action 1) does at most a key scan, a shift-down removal and a shift-insert, and
// returns one status result. All table traffic goes through one slot read and one slot
// write per cycle; output stalls can hold a tick's scan and an update's result. Requests
// are taken only when the previous one is finished.
module sorted_timer_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_action,
    input  logic [sttbl_pkg::TIME_BITS-1:0]     i_now,
    input  logic [sttbl_pkg::OWNER_W-1:0]       i_owner,
    input  logic [sttbl_pkg::MSG_W-1:0]         i_message_id,
    input  logic [sttbl_pkg::TIME_BITS-1:0]     i_interval,
    input  logic [sttbl_pkg::REP_W-1:0]         i_repeat_count,
    input  logic                                i_repeat_forever,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [sttbl_pkg::KIND_W-1:0]        o_kind,
    output logic [sttbl_pkg::OWNER_W-1:0]       o_owner_out,
    output logic [sttbl_pkg::MSG_W-1:0]         o_message_out,
    output logic [sttbl_pkg::TIME_BITS-1:0]     o_fire_time,
    output logic                                o_last
);

    sttbl_pkg::t_cmd    cmd;
    sttbl_pkg::t_status status;
    logic               busy;

    sttbl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    sttbl_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_action         (i_action),
        .i_now            (i_now),
        .i_owner          (i_owner),
        .i_message_id     (i_message_id),
        .i_interval       (i_interval),
        .i_repeat_count   (i_repeat_count),
        .i_repeat_forever (i_repeat_forever),
        .i_out_stall      (i_stall),
        .o_status         (status),
        .o_valid          (o_valid),
        .o_kind           (o_kind),
        .o_owner_out      (o_owner_out),
        .o_message_out    (o_message_out),
        .o_fire_time      (o_fire_time),
        .o_last           (o_last)
    );

    assign o_stall = busy;

endmodule
